>>> rtl/hid_report_key_press_detector_macros.svh
// Assertion macros shared by the HID report key press detector checker
`ifndef HID_REPORT_KEY_PRESS_DETECTOR_MACROS_SVH
`define HID_REPORT_KEY_PRESS_DETECTOR_MACROS_SVH

// same-cycle implication, checked on clk, disabled while rst is high
`define HRKPD_ASSERT_IMP(lbl, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, disabled while rst is high
`define HRKPD_ASSERT_NXT(lbl, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hrkpd_pkg.sv
// Shared types and constants of the HID report key press detector
package hrkpd_pkg;

  localparam int CARRIED_BYTES    = 8;
  localparam int KEY_START        = 2;
  localparam int KEYBOARD_MIN_LEN = 3;
  localparam int CONSUMER_MIN_LEN = 2;

  localparam logic EVT_KEY      = 1'b0;
  localparam logic EVT_CONSUMER = 1'b1;

  typedef logic [7:0] byte_t;

  // per-request data held while its events drain
  typedef struct packed {
    logic        kind;
    byte_t       modifier;
    logic [15:0] usage;
  } evt_hdr_t;

endpackage

>>> rtl/hid_report_key_press_detector.sv
// An accepted request is loaded into the merge stage's pending lanes, and its
// first event then goes into the output register. Events leave one per cycle
// while the output is not stalled; a request with events holds the input until
// its last event goes out. Eventless requests are taken one per cycle when idle.
// Reset (rst_n low, synchronous): key history and interface mask cleared.
module hid_report_key_press_detector
  import hrkpd_pkg::*;
#(
  parameter int INTERFACES = 4,
  parameter int ROLLOVER   = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_keyboard_interface_mask,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [1:0]  in_interface_index,
  input  logic [6:0]  in_report_length,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_event_kind,
  output logic [15:0] out_code,
  output logic [7:0]  out_modifier,
  output logic        out_last
);

  localparam int IW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;

  logic [3:0]          mask_r;
  byte_t               hist_r [INTERFACES][ROLLOVER];
  byte_t               rpt [CARRIED_BYTES];
  byte_t               prev_row [ROLLOVER];
  byte_t               lane_key [ROLLOVER];
  logic [ROLLOVER-1:0] lane_en, lane_press;
  logic [IW-1:0]       row_idx;
  logic                accept, is_kbd, kbd_rpt, cons_hit;
  logic [15:0]         usage;
  logic [ROLLOVER-1:0] load_mask;
  evt_hdr_t            load_hdr;

  assign rpt = '{in_byte0, in_byte1, in_byte2, in_byte3,
                 in_byte4, in_byte5, in_byte6, in_byte7};

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign row_idx  = IW'(in_interface_index);
  assign is_kbd   = (32'(in_interface_index) < INTERFACES) && mask_r[in_interface_index];
  assign kbd_rpt  = is_kbd && (in_report_length >= 7'(KEYBOARD_MIN_LEN));
  assign prev_row = hist_r[row_idx];

  // a two-byte request carries the usage alone, longer ones lead with a report ID
  assign usage    = (in_report_length == 7'(CONSUMER_MIN_LEN)) ? {in_byte1, in_byte0}
                                                              : {in_byte2, in_byte1};
  assign cons_hit = (in_report_length >= 7'(CONSUMER_MIN_LEN)) && (usage != 16'h0000);

  for (genvar i = 0; i < ROLLOVER; i++) begin : g_lane
    assign lane_key[i] = rpt[KEY_START + i];
    assign lane_en[i]  = in_report_length >= 7'(KEYBOARD_MIN_LEN + i);
    hrkpd_lane #(
      .ROLLOVER (ROLLOVER)
    ) u_lane (
      .en        (lane_en[i]),
      .key       (lane_key[i]),
      .hist_keys (prev_row),
      .press     (lane_press[i])
    );
  end

  always_comb begin
    load_hdr.kind     = kbd_rpt ? EVT_KEY : EVT_CONSUMER;
    load_hdr.modifier = kbd_rpt ? in_byte0 : 8'h00;
    load_hdr.usage    = usage;
    load_mask         = kbd_rpt ? lane_press : ROLLOVER'(cons_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int r = 0; r < INTERFACES; r++) begin
        for (int j = 0; j < ROLLOVER; j++) hist_r[r][j] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) mask_r <= cfg_keyboard_interface_mask;
      if (accept) begin
        if (in_mode) begin
          for (int r = 0; r < INTERFACES; r++) begin
            for (int j = 0; j < ROLLOVER; j++) hist_r[r][j] <= '0;
          end
        end else if (kbd_rpt) begin
          for (int j = 0; j < ROLLOVER; j++) begin
            hist_r[row_idx][j] <= lane_en[j] ? lane_key[j] : 8'h00;
          end
        end
      end
    end
  end

  hrkpd_merge #(
    .ROLLOVER (ROLLOVER)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept && !in_mode),
    .load_mask      (load_mask),
    .load_keys      (lane_key),
    .load_hdr       (load_hdr),
    .load_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_code       (out_code),
    .out_modifier   (out_modifier),
    .out_last       (out_last)
  );

endmodule

>>> rtl/hrkpd_lane.sv
// One keycode lane: flags a new press absent from the previous key list
module hrkpd_lane
  import hrkpd_pkg::*;
#(
  parameter int ROLLOVER = 6
) (
  input  logic  en,
  input  byte_t key,
  input  byte_t hist_keys [ROLLOVER],
  output logic  press
);

  logic seen;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < ROLLOVER; j++) begin
      if (hist_keys[j] == key) seen = 1'b1;
    end
  end

  assign press = en && (key != 8'h00) && !seen;

endmodule

>>> rtl/hrkpd_merge.sv
// Merge stage: holds a request's lane hits; one event per cycle unless stalled
module hrkpd_merge
  import hrkpd_pkg::*;
#(
  parameter int ROLLOVER = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [ROLLOVER-1:0] load_mask,
  input  byte_t               load_keys [ROLLOVER],
  input  evt_hdr_t            load_hdr,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_event_kind,
  output logic [15:0]         out_code,
  output logic [7:0]          out_modifier,
  output logic                out_last
);

  localparam int SW = (ROLLOVER > 1) ? $clog2(ROLLOVER) : 1;

  logic [ROLLOVER-1:0] pend_r, pend_nxt;
  byte_t               keys_r [ROLLOVER];
  evt_hdr_t            hdr_r;
  logic                out_valid_r;
  logic                out_kind_r, out_last_r;
  logic [15:0]         out_code_r;
  byte_t               out_mod_r;

  logic [SW-1:0]       sel;
  logic [ROLLOVER-1:0] sel_oh;
  logic                emit, can_load;

  // lowest pending lane goes first, keeping report order
  always_comb begin
    sel    = '0;
    sel_oh = '0;
    for (int i = ROLLOVER - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel    = SW'(i);
        sel_oh = ROLLOVER'(1) << i;
      end
    end
  end

  assign can_load   = !out_valid_r || out_ready;
  assign emit       = can_load && (pend_r != '0);
  assign pend_nxt   = pend_r & ~sel_oh;
  assign load_ready = (pend_r == '0) || (emit && (pend_nxt == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pend_r <= load_mask;
        keys_r <= load_keys;
        hdr_r  <= load_hdr;
      end else if (emit) begin
        pend_r <= pend_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= hdr_r.kind;
        out_mod_r   <= hdr_r.modifier;
        out_code_r  <= (hdr_r.kind == EVT_CONSUMER) ? hdr_r.usage : {8'h00, keys_r[sel]};
        out_last_r  <= (pend_nxt == '0);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_code       = out_code_r;
  assign out_modifier   = out_mod_r;
  assign out_last       = out_last_r;

endmodule

>>> rtl/hrkpd_checker.sv
// Port-level assertion checker for the HID report key press detector, with bind
`include "hid_report_key_press_detector_macros.svh"

module hrkpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_event_kind,
  input logic [15:0] out_code,
  input logic [7:0]  out_modifier,
  input logic        out_last
);

  // a stalled event keeps its payload
  `HRKPD_ASSERT_NXT(a_out_hold, !rst_n, out_valid && !out_ready,
    out_valid && $stable(out_code) && $stable(out_last) && $stable(out_event_kind),
    "stalled output event changed")

  // consumer usage is always a single, final event without modifier
  `HRKPD_ASSERT_IMP(a_cons_single, !rst_n, out_valid && out_event_kind,
    out_last && (out_modifier == 8'h00) && (out_code != 16'h0000),
    "consumer event malformed")

  // key presses carry a nonzero 8-bit keycode
  `HRKPD_ASSERT_IMP(a_key_code, !rst_n, out_valid && !out_event_kind,
    (out_code[15:8] == 8'h00) && (out_code[7:0] != 8'h00),
    "key press event with bad keycode")

  // reset leaves no event pending on the output
  `HRKPD_ASSERT_NXT(a_rst_idle, 1'b0, !rst_n, !out_valid,
    "output valid right after reset")

endmodule

bind hid_report_key_press_detector hrkpd_checker u_hrkpd_checker (.*);

>>> tb/hid_report_key_press_detector_test.sv
// Self-checking testbench for the HID report key press detector
`timescale 1ns / 1ps

module hid_report_key_press_detector_test;
  import hrkpd_pkg::*;

  localparam int NUM_IFACES     = 4;
  localparam int KEY_SLOTS      = 6;
  localparam int MAX_REPORT_LEN = 64;
  localparam int PHASE_ITEMS    = 32;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_LINES      = 40;

  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [1:0]                iface;
    logic [6:0]                length;
    byte_t [CARRIED_BYTES-1:0] data;
  } hid_request_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] code;
    byte_t       modifier;
    logic        last;
  } key_event_t;

  // Tracks per-interface key history and the events each request should raise
  class key_event_scoreboard;
    byte_t                 key_history[NUM_IFACES][KEY_SLOTS];
    logic [NUM_IFACES-1:0] kbd_mask;
    key_event_t            pending_events[$];
    int unsigned           mismatches;

    function new();
      wipe_history();
      kbd_mask   = '0;
      mismatches = 0;
    endfunction

    function void wipe_history();
      for (int i = 0; i < NUM_IFACES; i++)
        for (int j = 0; j < KEY_SLOTS; j++)
          key_history[i][j] = 8'h00;
    endfunction

    function void note_request(hid_request_t rq);
      key_event_t  evs[KEY_SLOTS];
      int          n;
      int unsigned len;
      int unsigned count;
      int unsigned off;
      logic [15:0] usage;
      byte_t       key;
      bit          seen;
      n = 0;
      if (rq.mode == MODE_CLEAR) begin
        wipe_history();
        return;
      end
      len = (rq.length > MAX_REPORT_LEN) ? MAX_REPORT_LEN : rq.length;
      if (kbd_mask[rq.iface] && len >= KEYBOARD_MIN_LEN) begin
        count = len - KEY_START;
        if (count > KEY_SLOTS) count = KEY_SLOTS;
        // compare against the old list only, so a key repeated in one report fires twice
        for (int i = 0; i < count; i++) begin
          key  = rq.data[KEY_START + i];
          seen = 1'b0;
          for (int j = 0; j < KEY_SLOTS; j++)
            if (key_history[rq.iface][j] == key) seen = 1'b1;
          if (key != 8'h00 && !seen) begin
            evs[n].kind     = EVT_KEY;
            evs[n].code     = {8'h00, key};
            evs[n].modifier = rq.data[0];
            n++;
          end
        end
        for (int j = 0; j < KEY_SLOTS; j++)
          key_history[rq.iface][j] = (j < count) ? rq.data[KEY_START + j] : 8'h00;
      end else if (len >= CONSUMER_MIN_LEN) begin
        // longer consumer reports carry a report ID in byte0
        off   = (len == CONSUMER_MIN_LEN) ? 0 : 1;
        usage = {rq.data[off + 1], rq.data[off]};
        if (usage != 16'h0000) begin
          evs[0].kind     = EVT_CONSUMER;
          evs[0].code     = usage;
          evs[0].modifier = 8'h00;
          n = 1;
        end
      end
      for (int i = 0; i < n; i++) begin
        evs[i].last = (i == n - 1);
        pending_events.push_back(evs[i]);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_LINES) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_event(key_event_t got);
      key_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind=%0d code=%h mod=%h last=%0d",
                         got.kind, got.code, got.modifier, got.last));
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
      if (got.code !== want.code)
        report($sformatf("code %h, want %h", got.code, want.code));
      if (got.modifier !== want.modifier)
        report($sformatf("modifier %h, want %h", got.modifier, want.modifier));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d (code %h)", got.last, want.last, want.code));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_keyboard_interface_mask;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [1:0]  in_interface_index;
  logic [6:0]  in_report_length;
  logic [7:0]  in_byte0;
  logic [7:0]  in_byte1;
  logic [7:0]  in_byte2;
  logic [7:0]  in_byte3;
  logic [7:0]  in_byte4;
  logic [7:0]  in_byte5;
  logic [7:0]  in_byte6;
  logic [7:0]  in_byte7;
  logic        out_valid;
  logic        out_ready;
  logic        out_event_kind;
  logic [15:0] out_code;
  logic [7:0]  out_modifier;
  logic        out_last;

  key_event_scoreboard board = new();
  int unsigned         cycle_count = 0;
  bit                  in_quiet = 1'b0;
  bit                  out_quiet = 1'b0;

  hid_report_key_press_detector #(
    .INTERFACES (NUM_IFACES),
    .ROLLOVER   (KEY_SLOTS)
  ) dut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .cfg_valid                   (cfg_valid),
    .cfg_ready                   (cfg_ready),
    .cfg_keyboard_interface_mask (cfg_keyboard_interface_mask),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .in_mode                     (in_mode),
    .in_interface_index          (in_interface_index),
    .in_report_length            (in_report_length),
    .in_byte0                    (in_byte0),
    .in_byte1                    (in_byte1),
    .in_byte2                    (in_byte2),
    .in_byte3                    (in_byte3),
    .in_byte4                    (in_byte4),
    .in_byte5                    (in_byte5),
    .in_byte6                    (in_byte6),
    .in_byte7                    (in_byte7),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .out_event_kind              (out_event_kind),
    .out_code                    (out_code),
    .out_modifier                (out_modifier),
    .out_last                    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_event({out_event_kind, out_code, out_modifier, out_last});
  end

  // event sink: random stall before each event, none while out_quiet is set
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 5);
      repeat (stall) @(negedge clk) out_ready <= 1'b0;
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
    end
  end

  function automatic hid_request_t report_of(logic [1:0] iface, logic [6:0] len,
                                             logic [63:0] bytes);
    hid_request_t rq;
    rq.mode   = MODE_REPORT;
    rq.iface  = iface;
    rq.length = len;
    rq.data   = bytes;
    return rq;
  endfunction

  function automatic hid_request_t random_request(logic [3:0] mask);
    hid_request_t rq;
    int           pick;
    rq.mode   = MODE_REPORT;
    rq.iface  = 2'($urandom_range(0, 3));
    rq.length = 7'd8;
    for (int i = 0; i < CARRIED_BYTES; i++) rq.data[i] = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      rq.mode = MODE_CLEAR;
    end else if (pick < 70) begin
      // keyboard report; keys from a small pool so presses and holds both occur
      if (mask != 4'h0)
        while (!mask[rq.iface]) rq.iface = 2'($urandom_range(0, 3));
      for (int i = KEY_START; i < CARRIED_BYTES; i++) begin
        case ($urandom_range(0, 9))
          0:       rq.data[i] = 8'h00;
          1:       rq.data[i] = 8'($urandom);
          default: rq.data[i] = 8'(4 + $urandom_range(0, 9));
        endcase
      end
      case ($urandom_range(0, 7))
        0:       rq.length = 7'($urandom_range(3, 7));
        1:       rq.length = 7'($urandom_range(9, 127));
        default: rq.length = 7'd8;
      endcase
    end else if (pick < 88) begin
      rq.length = $urandom_range(0, 1) ? 7'd2 : 7'($urandom_range(3, 10));
      if ($urandom_range(0, 7) == 0) begin
        rq.data[0] = 8'h00;
        rq.data[1] = 8'h00;
        rq.data[2] = 8'h00;
      end
    end else begin
      rq.length = 7'($urandom_range(0, 127));
    end
    return rq;
  endfunction

  task automatic send_request(hid_request_t rq);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_mode            <= rq.mode;
    in_interface_index <= rq.iface;
    in_report_length   <= rq.length;
    in_byte0           <= rq.data[0];
    in_byte1           <= rq.data[1];
    in_byte2           <= rq.data[2];
    in_byte3           <= rq.data[3];
    in_byte4           <= rq.data[4];
    in_byte5           <= rq.data[5];
    in_byte6           <= rq.data[6];
    in_byte7           <= rq.data[7];
    do @(posedge clk); while (!in_ready);
    board.note_request(rq);
  endtask

  // clear requests raise no event, so allow the pipeline to empty after the last one
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [3:0] mask);
    @(negedge clk);
    cfg_valid                   <= 1'b1;
    cfg_keyboard_interface_mask <= mask;
    do @(posedge clk); while (!cfg_ready);
    board.kbd_mask = mask;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    hid_request_t rq;
    logic [3:0]   phase_masks[6];
    rst_n                       = 1'b0;
    cfg_valid                   = 1'b0;
    cfg_keyboard_interface_mask = 4'h0;
    in_valid                    = 1'b0;
    in_mode                     = MODE_REPORT;
    in_interface_index          = 2'd0;
    in_report_length            = 7'd0;
    in_byte0                    = 8'h00;
    in_byte1                    = 8'h00;
    in_byte2                    = 8'h00;
    in_byte3                    = 8'h00;
    in_byte4                    = 8'h00;
    in_byte5                    = 8'h00;
    in_byte6                    = 8'h00;
    in_byte7                    = 8'h00;
    phase_masks = '{4'hF, 4'h0, 4'b0101, 4'b1010, 4'($urandom), 4'hF};

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // no keyboard interfaces yet: everything decodes as consumer usage
    send_request(report_of(2'd0, 7'd0,   64'hFFEE_DDCC_BBAA_3412));
    send_request(report_of(2'd1, 7'd1,   64'h0000_0000_0000_3412));
    send_request(report_of(2'd2, 7'd2,   64'hFFFF_FFFF_FF77_3412));
    send_request(report_of(2'd3, 7'd3,   64'h0000_0000_00FF_FF01));
    send_request(report_of(2'd0, 7'd127, 64'hFFFF_FFFF_FF00_0002));
    send_request(report_of(2'd1, 7'd64,  64'h1111_1111_0000_E903));
    wait_idle();
    write_mask(4'hF);

    // six new keys, then the same report held, then a partial change with a repeat
    send_request(report_of(2'd0, 7'd8,   64'h0908_0706_0504_00FF));
    send_request(report_of(2'd0, 7'd8,   64'h0908_0706_0504_00FF));
    send_request(report_of(2'd0, 7'd8,   64'hFF04_0A00_0A05_AA00));
    send_request(report_of(2'd0, 7'd3,   64'h7777_7777_7704_0011));
    send_request(report_of(2'd1, 7'd2,   64'h0000_0000_0000_CDAB));
    send_request(report_of(2'd2, 7'd127, 64'h1716_1514_1312_0080));
    send_request(report_of(2'd2, 7'd64,  64'h1817_1615_1413_0080));
    send_request(report_of(2'd3, 7'd5,   64'h2A2A_2A1F_1E1D_0001));
    rq      = report_of(2'($urandom), 7'($urandom), {$urandom, $urandom});
    rq.mode = MODE_CLEAR;
    send_request(rq);
    send_request(report_of(2'd0, 7'd8,   64'h0908_0706_0504_00FF));
    wait_idle();
    write_mask(4'b0101);

    send_request(report_of(2'd1, 7'd8,   64'h0000_0000_0C00_E201));
    send_request(report_of(2'd2, 7'd8,   64'h0000_2C2B_2A29_0002));
    send_request(report_of(2'd3, 7'd1,   64'hFFFF_FFFF_FFFF_FFFF));
    wait_idle();

    foreach (phase_masks[p]) begin
      write_mask(phase_masks[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
        if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
        send_request(random_request(phase_masks[p]));
      end
      wait_idle();
    end

    if (board.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hrkpd_pkg.sv
rtl/hrkpd_lane.sv
rtl/hrkpd_merge.sv
rtl/hid_report_key_press_detector.sv
rtl/hrkpd_checker.sv
tb/hid_report_key_press_detector_test.sv
